// ===== design/gcb_pkg.sv =====
package gcb_pkg;

  // Default width of the price and paid amounts.
  localparam int AMOUNT_WIDTH_DEF = 24;

  // Note set, largest first.
  localparam int NOTE_KINDS = 7;
  localparam int NOTE_IDX_W = 3;
  localparam int NOTE_TOP   = 100000;
  localparam int NOTE_MIN   = 1000;

  // Result field widths.
  localparam int VALUE_W = 17;
  localparam int COUNT_W = 15;
  localparam int LEFT_W  = 10;

  // The remainder after the largest note is always below it.
  localparam int REST_W = 17;

  // Every note below the largest is used at most twice.
  localparam int SMALL_W   = 2;
  localparam int SMALL_VEC = (NOTE_KINDS - 1) * SMALL_W;

  // Count saturation limit.
  localparam int COUNT_MAX = 32767;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_NOTE  = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_EXACT = 2'd2,
    STATUS_SMALL = 2'd3
  } status_t;

  // Face value of each note, largest first.
  function automatic logic [VALUE_W-1:0] note_value(input logic [NOTE_IDX_W-1:0] idx);
    logic [VALUE_W-1:0] v;
    unique case (idx)
      3'd0:    v = 17'd100000;
      3'd1:    v = 17'd50000;
      3'd2:    v = 17'd20000;
      3'd3:    v = 17'd10000;
      3'd4:    v = 17'd5000;
      3'd5:    v = 17'd2000;
      3'd6:    v = 17'd1000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/greedy_change_breakdown_unit.sv =====
// Each item passes in order through the subtractor stage, one divider stage per quotient bit,
// the note stages, the hold register and the output register.
// Throughput: one result per cycle while out_stall is low; an item gives 1 to 7 results.
// The output stage that sends the results one by one sets that rate; the pipeline before it
// takes a new item in every cycle while the output stage keeps up.
// Reset: synchronous, active low; clears every valid bit. No state is kept between items.
module greedy_change_breakdown_unit
  import gcb_pkg::*;
#(
  parameter int AMOUNT_WIDTH = AMOUNT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [AMOUNT_WIDTH-1:0] in_price,
  input  logic [AMOUNT_WIDTH-1:0] in_paid,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [VALUE_W-1:0]      out_note_value,
  output logic [COUNT_W-1:0]      out_note_count,
  output logic [AMOUNT_WIDTH-1:0] out_change_total,
  output logic [LEFT_W-1:0]       out_leftover,
  output logic                    out_last
);

  localparam int AW = AMOUNT_WIDTH;
  // The largest note exceeds 2^16, so the quotient needs AW - 16 bits.
  localparam int QW = AMOUNT_WIDTH - 16;

  logic          sub_ready;

  // Divider chain; entry 0 is the subtractor output.
  logic          div_valid  [QW+1];
  logic          div_ready  [QW+1];
  status_t       div_kind   [QW+1];
  logic [AW-1:0] div_change [QW+1];
  logic [AW-1:0] div_rem    [QW+1];
  logic [QW-1:0] div_quot   [QW+1];

  // Note chain; entry 0 is the divider output.
  logic                 nt_valid  [NOTE_KINDS];
  logic                 nt_ready  [NOTE_KINDS];
  status_t              nt_kind   [NOTE_KINDS];
  logic [AW-1:0]        nt_change [NOTE_KINDS];
  logic [QW-1:0]        nt_quot   [NOTE_KINDS];
  logic [REST_W-1:0]    nt_rem    [NOTE_KINDS];
  logic [SMALL_VEC-1:0] nt_cnts   [NOTE_KINDS];

  status_t out_status_e;

  assign in_stall = !sub_ready;

  // Change and outcome class.
  gcb_sub_stage #(.AW(AW)) u_sub (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (sub_ready),
    .price     (in_price),
    .paid      (in_paid),
    .dn_valid  (div_valid[0]),
    .dn_ready  (div_ready[0]),
    .dn_kind   (div_kind[0]),
    .dn_change (div_change[0])
  );

  assign div_rem[0]  = div_change[0];
  assign div_quot[0] = '0;

  // One quotient bit per stage, most significant first.
  for (genvar i = 0; i < QW; i++) begin : g_div
    gcb_div_stage #(.AW(AW), .QW(QW), .BIT(QW - 1 - i)) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (div_valid[i]),
      .up_ready  (div_ready[i]),
      .up_kind   (div_kind[i]),
      .up_change (div_change[i]),
      .up_rem    (div_rem[i]),
      .up_quot   (div_quot[i]),
      .dn_valid  (div_valid[i+1]),
      .dn_ready  (div_ready[i+1]),
      .dn_kind   (div_kind[i+1]),
      .dn_change (div_change[i+1]),
      .dn_rem    (div_rem[i+1]),
      .dn_quot   (div_quot[i+1])
    );
  end

  // Hand-over from the divider; the remainder is now below the largest note.
  assign nt_valid[0]   = div_valid[QW];
  assign div_ready[QW] = nt_ready[0];
  assign nt_kind[0]    = div_kind[QW];
  assign nt_change[0]  = div_change[QW];
  assign nt_quot[0]    = div_quot[QW];
  assign nt_rem[0]     = div_rem[QW][REST_W-1:0];
  assign nt_cnts[0]    = '0;

  // One smaller note per stage.
  for (genvar k = 1; k < NOTE_KINDS; k++) begin : g_note
    gcb_note_stage #(.AW(AW), .QW(QW), .NOTE(k)) u_note (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (nt_valid[k-1]),
      .up_ready  (nt_ready[k-1]),
      .up_kind   (nt_kind[k-1]),
      .up_change (nt_change[k-1]),
      .up_quot   (nt_quot[k-1]),
      .up_rem    (nt_rem[k-1]),
      .up_cnts   (nt_cnts[k-1]),
      .dn_valid  (nt_valid[k]),
      .dn_ready  (nt_ready[k]),
      .dn_kind   (nt_kind[k]),
      .dn_change (nt_change[k]),
      .dn_quot   (nt_quot[k]),
      .dn_rem    (nt_rem[k]),
      .dn_cnts   (nt_cnts[k])
    );
  end

  // Results, one per cycle while out_stall is low.
  gcb_emit #(.AW(AW), .QW(QW)) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_valid         (nt_valid[NOTE_KINDS-1]),
    .up_ready         (nt_ready[NOTE_KINDS-1]),
    .up_kind          (nt_kind[NOTE_KINDS-1]),
    .up_change        (nt_change[NOTE_KINDS-1]),
    .up_quot          (nt_quot[NOTE_KINDS-1]),
    .up_cnts          (nt_cnts[NOTE_KINDS-1]),
    .up_left          (nt_rem[NOTE_KINDS-1][LEFT_W-1:0]),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status_e),
    .out_note_value   (out_note_value),
    .out_note_count   (out_note_count),
    .out_change_total (out_change_total),
    .out_leftover     (out_leftover),
    .out_last         (out_last)
  );

  assign out_status = out_status_e;

  // Outcomes other than notes close the item with empty note fields.
  a_special_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_e != STATUS_NOTE |->
      out_last && out_note_value == '0 && out_note_count == '0)
    else $error("special outcome result is not a single empty closing result");

  // Leftover is given on the closing result only.
  a_leftover_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_leftover == '0)
    else $error("leftover on a result that is not the last");

  // Note results only come with change of at least the smallest note.
  a_note_change : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_e == STATUS_NOTE |-> out_change_total >= AW'(NOTE_MIN))
    else $error("note result with change below the smallest note");

  // Notes of one item follow back to back, largest first.
  a_note_order : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && out_status_e == STATUS_NOTE &&
      out_note_value < $past(out_note_value))
    else $error("notes of one item not sent back to back in falling order");

endmodule

// ===== design/gcb_sub_stage.sv =====
module gcb_sub_stage
  import gcb_pkg::*;
#(
  parameter int AW = AMOUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  logic [AW-1:0] price,
  input  logic [AW-1:0] paid,
  output logic          dn_valid,
  input  logic          dn_ready,
  output status_t       dn_kind,
  output logic [AW-1:0] dn_change
);

  logic          valid_r;
  status_t       kind_r;
  status_t       kind_nxt;
  logic [AW-1:0] change_r;
  logic [AW-1:0] change_nxt;
  logic [AW:0]   diff;

  assign up_ready = !valid_r || dn_ready;

  // Change and outcome class; a short payment carries no change.
  always_comb begin
    diff = {1'b0, paid} - {1'b0, price};
    if (diff[AW]) begin
      kind_nxt   = STATUS_SHORT;
      change_nxt = '0;
    end else begin
      change_nxt = diff[AW-1:0];
      if (diff[AW-1:0] == '0) begin
        kind_nxt = STATUS_EXACT;
      end else if (diff[AW-1:0] < AW'(NOTE_MIN)) begin
        kind_nxt = STATUS_SMALL;
      end else begin
        kind_nxt = STATUS_NOTE;
      end
    end
  end

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      kind_r   <= kind_nxt;
      change_r <= change_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_kind   = kind_r;
  assign dn_change = change_r;

endmodule

// ===== design/gcb_div_stage.sv =====
module gcb_div_stage
  import gcb_pkg::*;
#(
  parameter int AW  = AMOUNT_WIDTH_DEF,
  parameter int QW  = AMOUNT_WIDTH_DEF - 16,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  status_t       up_kind,
  input  logic [AW-1:0] up_change,
  input  logic [AW-1:0] up_rem,
  input  logic [QW-1:0] up_quot,
  output logic          dn_valid,
  input  logic          dn_ready,
  output status_t       dn_kind,
  output logic [AW-1:0] dn_change,
  output logic [AW-1:0] dn_rem,
  output logic [QW-1:0] dn_quot
);

  // Largest note shifted to the weight of this quotient bit.
  localparam logic [AW-1:0] STEP = AW'(64'(NOTE_TOP) << BIT);

  logic          valid_r;
  status_t       kind_r;
  logic [AW-1:0] change_r;
  logic [AW-1:0] rem_r;
  logic [AW-1:0] rem_nxt;
  logic [QW-1:0] quot_r;
  logic [QW-1:0] quot_nxt;

  assign up_ready = !valid_r || dn_ready;

  // One restoring step of the division by the largest note.
  always_comb begin
    quot_nxt = up_quot;
    rem_nxt  = up_rem;
    if (up_rem >= STEP) begin
      rem_nxt       = up_rem - STEP;
      quot_nxt[BIT] = 1'b1;
    end
  end

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      kind_r   <= up_kind;
      change_r <= up_change;
      rem_r    <= rem_nxt;
      quot_r   <= quot_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_kind   = kind_r;
  assign dn_change = change_r;
  assign dn_rem    = rem_r;
  assign dn_quot   = quot_r;

endmodule

// ===== design/gcb_note_stage.sv =====
module gcb_note_stage
  import gcb_pkg::*;
#(
  parameter int AW   = AMOUNT_WIDTH_DEF,
  parameter int QW   = AMOUNT_WIDTH_DEF - 16,
  parameter int NOTE = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  status_t              up_kind,
  input  logic [AW-1:0]        up_change,
  input  logic [QW-1:0]        up_quot,
  input  logic [REST_W-1:0]    up_rem,
  input  logic [SMALL_VEC-1:0] up_cnts,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output status_t              dn_kind,
  output logic [AW-1:0]        dn_change,
  output logic [QW-1:0]        dn_quot,
  output logic [REST_W-1:0]    dn_rem,
  output logic [SMALL_VEC-1:0] dn_cnts
);

  localparam logic [REST_W-1:0] VAL  = note_value(NOTE_IDX_W'(NOTE));
  localparam logic [REST_W:0]   VAL2 = {VAL, 1'b0};

  logic                 valid_r;
  status_t              kind_r;
  logic [AW-1:0]        change_r;
  logic [QW-1:0]        quot_r;
  logic [REST_W-1:0]    rem_r;
  logic [REST_W-1:0]    rem_nxt;
  logic [SMALL_VEC-1:0] cnts_r;
  logic [SMALL_VEC-1:0] cnts_nxt;
  logic [SMALL_W-1:0]   cnt;

  assign up_ready = !valid_r || dn_ready;

  // The remainder is below the previous note, so this note fits at most twice.
  always_comb begin
    if ({1'b0, up_rem} >= VAL2) begin
      cnt     = 2'd2;
      rem_nxt = REST_W'({1'b0, up_rem} - VAL2);
    end else if (up_rem >= VAL) begin
      cnt     = 2'd1;
      rem_nxt = up_rem - VAL;
    end else begin
      cnt     = 2'd0;
      rem_nxt = up_rem;
    end
    cnts_nxt = up_cnts;
    cnts_nxt[(NOTE-1)*SMALL_W +: SMALL_W] = cnt;
  end

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      kind_r   <= up_kind;
      change_r <= up_change;
      quot_r   <= up_quot;
      rem_r    <= rem_nxt;
      cnts_r   <= cnts_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_kind   = kind_r;
  assign dn_change = change_r;
  assign dn_quot   = quot_r;
  assign dn_rem    = rem_r;
  assign dn_cnts   = cnts_r;

endmodule

// ===== design/gcb_emit.sv =====
module gcb_emit
  import gcb_pkg::*;
#(
  parameter int AW = AMOUNT_WIDTH_DEF,
  parameter int QW = AMOUNT_WIDTH_DEF - 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  status_t              up_kind,
  input  logic [AW-1:0]        up_change,
  input  logic [QW-1:0]        up_quot,
  input  logic [SMALL_VEC-1:0] up_cnts,
  input  logic [LEFT_W-1:0]    up_left,
  output logic                 out_valid,
  input  logic                 out_stall,
  output status_t              out_status,
  output logic [VALUE_W-1:0]   out_note_value,
  output logic [COUNT_W-1:0]   out_note_count,
  output logic [AW-1:0]        out_change_total,
  output logic [LEFT_W-1:0]    out_leftover,
  output logic                 out_last
);

  // Item being broken into results.
  logic                  hold_valid_r;
  status_t               kind_r;
  logic [AW-1:0]         change_r;
  logic [QW-1:0]         quot_r;
  logic [SMALL_VEC-1:0]  cnts_r;
  logic [LEFT_W-1:0]     left_r;
  logic [NOTE_KINDS-1:0] mask_r;
  logic [NOTE_KINDS-1:0] mask_in;

  // Output register.
  logic                  out_valid_r;
  status_t               status_r;
  logic [VALUE_W-1:0]    value_r;
  logic [COUNT_W-1:0]    count_r;
  logic [AW-1:0]         total_r;
  logic [LEFT_W-1:0]     leftover_r;
  logic                  last_r;

  logic                  out_free;
  logic                  emit;
  logic                  done;
  logic [NOTE_KINDS-1:0] sel;
  logic                  last_pick;
  logic [VALUE_W-1:0]    pick_value;
  logic [COUNT_W-1:0]    pick_count;

  // Notes in use by the incoming item.
  always_comb begin
    mask_in[0] = up_quot != '0;
    for (int k = 1; k < NOTE_KINDS; k++) begin
      mask_in[k] = up_cnts[(k-1)*SMALL_W +: SMALL_W] != '0;
    end
  end

  // Pick the largest note still to be given and its count.
  always_comb begin
    sel       = mask_r & (~mask_r + 1'b1);
    last_pick = (mask_r & ~sel) == '0;
    if (32'(quot_r) > 32'(COUNT_MAX)) begin
      pick_count = COUNT_W'(COUNT_MAX);
    end else begin
      pick_count = COUNT_W'(quot_r);
    end
    pick_value = note_value('0);
    for (int k = 1; k < NOTE_KINDS; k++) begin
      if (sel[k]) begin
        pick_value = note_value(NOTE_IDX_W'(k));
        pick_count = COUNT_W'(cnts_r[(k-1)*SMALL_W +: SMALL_W]);
      end
    end
  end

  // A result moves to the output register whenever it is free.
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = hold_valid_r && out_free;
  assign done     = emit && ((kind_r != STATUS_NOTE) || last_pick);
  assign up_ready = !hold_valid_r || done;

  // Hold register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (up_ready) begin
      hold_valid_r <= up_valid;
    end
  end

  // Hold register payload; each note is struck off once it is sent.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      kind_r   <= up_kind;
      change_r <= up_change;
      quot_r   <= up_quot;
      cnts_r   <= up_cnts;
      left_r   <= up_left;
      mask_r   <= mask_in;
    end else if (emit) begin
      mask_r <= mask_r & ~sel;
    end
  end

  // Output valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  // Output payload. Outcomes other than notes give a single closing result.
  always_ff @(posedge clk) begin
    if (emit) begin
      total_r <= change_r;
      if (kind_r != STATUS_NOTE) begin
        status_r   <= kind_r;
        value_r    <= '0;
        count_r    <= '0;
        leftover_r <= left_r;
        last_r     <= 1'b1;
      end else begin
        status_r   <= STATUS_NOTE;
        value_r    <= pick_value;
        count_r    <= pick_count;
        leftover_r <= last_pick ? left_r : '0;
        last_r     <= last_pick;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_note_value   = value_r;
  assign out_note_count   = count_r;
  assign out_change_total = total_r;
  assign out_leftover     = leftover_r;
  assign out_last         = last_r;

endmodule
